### hw/rtl/b40_pkg.sv
package b40_pkg;

  localparam int ADDR_W      = 48;
  localparam int STATUS_W    = 3;
  localparam int CHAR_W      = 7;
  localparam int POS_W       = 4;
  localparam int RADIX       = 40;
  localparam int DIGIT_W     = 6;
  localparam int CONV_DIGITS = 9;
  localparam int NUM_CHARS   = 9;
  localparam int CHAR_COUNT  = (NUM_CHARS < 1) ? 1 : ((NUM_CHARS > 9) ? 9 : NUM_CHARS);

  // binary to base-40 conversion consumes this many address bits per cycle; the last chunk waits for room in the queue
  localparam int CHUNK_W     = 6;
  localparam int STEPS       = ADDR_W / CHUNK_W;
  localparam int STEP_CNT_W  = $clog2(STEPS);

  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [ADDR_W-1:0] ADDR_ALL_ONES     = 48'hFFFF_FFFF_FFFF;
  localparam logic [ADDR_W-1:0] ADDR_RESERVED_LOW = 48'hEE6B_2800_0000;

  typedef enum logic [STATUS_W-1:0] {
    ST_CHAR      = 3'd0,
    ST_BROADCAST = 3'd1,
    ST_UNKNOWN   = 3'd2,
    ST_RES_ZERO  = 3'd3,
    ST_RES_HIGH  = 3'd4
  } status_t;

  typedef enum logic {
    FE_IDLE,
    FE_CONV
  } fe_state_t;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef digit_t [CONV_DIGITS-1:0] digits_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              kind;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [CHAR_W-1:0] character;
    logic [POS_W-1:0]  position;
    logic              last;
  } out_t;

  // one classified address waiting for the back end
  typedef struct packed {
    status_t status;
    digits_t digits;
  } qent_t;

  localparam logic [CHAR_W-1:0] ALPHABET [RADIX] = '{
    7'h20, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49,
    7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h53,
    7'h54, 7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A, 7'h30, 7'h31, 7'h32,
    7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h2D, 7'h2F, 7'h2E
  };

  function automatic logic [CHAR_W-1:0] char_of(digit_t d);
    logic [CHAR_W-1:0] ch;
    ch = '0;
    if (d < DIGIT_W'(RADIX)) begin
      ch = ALPHABET[d];
    end
    return ch;
  endfunction

  // double the base-40 number and add one bit; each digit's carry depends on
  // its own value only, so the digits update side by side
  function automatic digits_t conv_bit(digits_t d, logic b);
    digits_t              r;
    logic [CONV_DIGITS:0] c;
    c[0] = b;
    for (int i = 0; i < CONV_DIGITS; i++) begin
      c[i+1] = (d[i] >= DIGIT_W'(RADIX / 2));
      if (c[i+1]) begin
        r[i] = DIGIT_W'({1'b0, d[i], c[i]} - (DIGIT_W + 2)'(RADIX));
      end else begin
        r[i] = DIGIT_W'({d[i], c[i]});
      end
    end
    return r;
  endfunction

  function automatic digits_t conv_chunk(digits_t d, logic [CHUNK_W-1:0] c);
    digits_t r;
    r = d;
    for (int j = CHUNK_W - 1; j >= 0; j--) begin
      r = conv_bit(r, c[j]);
    end
    return r;
  endfunction

endpackage

### hw/rtl/base40_callsign_decoder.sv
// Base-40 station address decoder.
//
// Input channel (in_valid / in_stall / in_data): one transaction carries a
// 48-bit encoded address and a kind bit (0 destination, 1 source).
// Output channel (out_valid / out_stall / out_data): a valid address gives
// nine character transactions, least significant digit first, position 0 to
// 8, last set on the ninth. All ones (broadcast or unknown source), zero and
// values at or above 40^9 give a single status transaction with last set.
// Timing: a status result reaches the output through the queue and the output
// register; a valid address is first turned from binary into base 40 six
// address bits per cycle, the last chunk waiting for room in the queue. The
// front end takes special addresses every cycle while the queue has room and
// no new address while it converts one; the back end emits one result per
// cycle while the output is not stalled, so valid addresses are paced by the
// character output. A two-entry queue separates the two halves, so a stall on
// the output only backs up the input once the queue is full.
// Reset (synchronous, rst_n low) empties the queue and drops any transaction
// in progress; no clearing pass is needed.
module base40_callsign_decoder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  b40_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output b40_pkg::out_t out_data
);
  import b40_pkg::*;

  qent_t q_wdata;
  qent_t q_rdata;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;

  // classify and convert
  b40_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  // hold classified addresses while the back end drains
  b40_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // emit one character or status result per cycle while the output is not stalled
  b40_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/b40_queue.sv
module b40_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b40_pkg::qent_t wdata,
  input  logic           pop,
  output b40_pkg::qent_t rdata,
  output logic           full,
  output logic           empty
);
  import b40_pkg::*;

  qent_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign empty   = (count_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### hw/rtl/b40_front.sv
module b40_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  b40_pkg::in_t   in_data,
  output logic           q_push,
  output b40_pkg::qent_t q_wdata,
  input  logic           q_full
);
  import b40_pkg::*;

  fe_state_t               state_r, state_nxt;
  logic [STEP_CNT_W-1:0]   cnt_r, cnt_nxt;
  digits_t                 dig_r, dig_nxt;
  logic [ADDR_W-1:0]       bits_r, bits_nxt;
  logic                    accept;
  logic                    is_ones, is_zero, is_high;
  logic                    final_step;
  digits_t                 stepped;

  assign in_stall   = (state_r != FE_IDLE) | q_full;
  assign accept     = in_valid & ~in_stall;
  assign is_ones    = (in_data.address == ADDR_ALL_ONES);
  assign is_zero    = (in_data.address == '0);
  assign is_high    = (in_data.address >= ADDR_RESERVED_LOW);
  assign final_step = (cnt_r == STEP_CNT_W'(STEPS - 1));
  assign stepped    = conv_chunk(dig_r, bits_r[ADDR_W-1 -: CHUNK_W]);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FE_IDLE: begin
        if (accept && !is_ones && !is_zero && !is_high) begin
          state_nxt = FE_CONV;
        end
      end
      FE_CONV: begin
        if (final_step && !q_full) begin
          state_nxt = FE_IDLE;
        end
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  // datapath and queue write
  always_comb begin
    cnt_nxt        = cnt_r;
    dig_nxt        = dig_r;
    bits_nxt       = bits_r;
    q_push         = 1'b0;
    q_wdata.status = ST_CHAR;
    q_wdata.digits = stepped;
    case (state_r)
      FE_IDLE: begin
        if (accept) begin
          if (is_ones) begin
            q_push         = 1'b1;
            q_wdata.status = in_data.kind ? ST_UNKNOWN : ST_BROADCAST;
            q_wdata.digits = '0;
          end else if (is_zero) begin
            q_push         = 1'b1;
            q_wdata.status = ST_RES_ZERO;
            q_wdata.digits = '0;
          end else if (is_high) begin
            q_push         = 1'b1;
            q_wdata.status = ST_RES_HIGH;
            q_wdata.digits = '0;
          end else begin
            dig_nxt  = conv_chunk('0, in_data.address[ADDR_W-1 -: CHUNK_W]);
            bits_nxt = in_data.address << CHUNK_W;
            cnt_nxt  = STEP_CNT_W'(1);
          end
        end
      end
      FE_CONV: begin
        if (!final_step) begin
          dig_nxt  = stepped;
          bits_nxt = bits_r << CHUNK_W;
          cnt_nxt  = cnt_r + 1'b1;
        end else if (!q_full) begin
          q_push = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r  <= dig_nxt;
    bits_r <= bits_nxt;
  end

endmodule

### hw/rtl/b40_back.sv
module b40_back (
  input  logic           clk,
  input  logic           rst_n,
  input  b40_pkg::qent_t q_rdata,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output b40_pkg::out_t  out_data
);
  import b40_pkg::*;

  qent_t             cur_r, cur_nxt;
  logic              active_r, active_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;
  qent_t             src;
  logic [POS_W-1:0]  pos;
  logic              advance;
  logic              is_last;

  assign src     = active_r ? cur_r : q_rdata;
  assign pos     = active_r ? pos_r : '0;
  assign advance = (~out_valid_r | ~out_stall) & (active_r | ~q_empty);
  assign q_pop   = advance & ~active_r;
  assign is_last = (src.status != ST_CHAR) || (pos == POS_W'(CHAR_COUNT - 1));

  always_comb begin
    cur_nxt       = cur_r;
    active_nxt    = active_r;
    pos_nxt       = pos_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (advance) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.status    = src.status;
      out_data_nxt.character = (src.status == ST_CHAR) ? char_of(src.digits[0]) : '0;
      out_data_nxt.position  = pos;
      out_data_nxt.last      = is_last;
      active_nxt             = ~is_last;
      pos_nxt                = pos + 1'b1;
      cur_nxt.status         = src.status;
      cur_nxt.digits         = digits_t'(src.digits >> DIGIT_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### dv/base40_callsign_decoder_tb.sv
`timescale 1ns / 1ps

module base40_callsign_decoder_tb;
  import b40_pkg::*;

  localparam int                CHARS_PER_ADDR = 9;
  localparam logic [ADDR_W-1:0] ALL_ONES       = 48'hFFFF_FFFF_FFFF;
  // 40^9: the first address that no longer fits in nine base-40 digits
  localparam logic [ADDR_W-1:0] SPELL_CEILING  = 48'hEE6B_2800_0000;
  localparam int                RANDOM_ITEMS   = 430;
  localparam int                HOLD_OFF_LEN   = 200;
  localparam int                SETTLE_CYCLES  = 24;

  // Scoreboard: predicts the transactions that each accepted address should
  // produce and checks the output stream against them in order.
  class callsign_ledger;
    out_t awaited[$];
    int   errors;
    int   results_seen;
    int   spelled;
    int   flagged;

    // Map one base-40 digit onto its character: space, A-Z, 0-9, '-', '/', '.'
    function logic [CHAR_W-1:0] glyph(int unsigned d);
      if (d == 0) return 7'h20;
      if (d <= 26) return 7'(8'h41 + d - 1);
      if (d <= 36) return 7'(8'h30 + d - 27);
      if (d == 37) return 7'h2D;
      if (d == 38) return 7'h2F;
      return 7'h2E;
    endfunction

    function void note_address(in_t item);
      out_t        r;
      logic [47:0] rest;
      r = '0;
      r.last = 1'b1;
      // all ones comes first, so it never reads as reserved high
      if (item.address == ALL_ONES) begin
        r.status = item.kind ? ST_UNKNOWN : ST_BROADCAST;
      end else if (item.address == '0) begin
        r.status = ST_RES_ZERO;
      end else if (item.address >= SPELL_CEILING) begin
        r.status = ST_RES_HIGH;
      end else begin
        rest = item.address;
        for (int p = 0; p < CHARS_PER_ADDR; p++) begin
          r.status    = ST_CHAR;
          r.character = glyph(int'(rest % 40));
          r.position  = POS_W'(p);
          r.last      = (p == CHARS_PER_ADDR - 1);
          awaited.push_back(r);
          rest = rest / 40;
        end
        spelled++;
        return;
      end
      flagged++;
      awaited.push_back(r);
    endfunction

    function void check_character(out_t got);
      out_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: unexpected transaction status=%0d char=%h pos=%0d last=%b",
                   $realtime, got.status, got.character, got.position, got.last);
        end
        return;
      end
      want = awaited.pop_front();
      if (got.status != want.status || got.character != want.character ||
          got.position != want.position || got.last != want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch: expected status=%0d char=%h pos=%0d last=%b",
                   $realtime, want.status, want.character, want.position, want.last);
          $display("%0t:           got      status=%0d char=%h pos=%0d last=%b",
                   $realtime, got.status, got.character, got.position, got.last);
        end
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  callsign_ledger ledger;
  // calm: neither side idles; hold_req: ask the receiver for a long hold-off
  bit calm;
  bit hold_req;
  int backpressure_cycles;

  base40_callsign_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offer one address from a falling edge and hold it until the block takes
  // it; return on the falling edge after acceptance with valid still high,
  // so that back-to-back transactions never drop valid in between.
  task automatic send_address(input logic [ADDR_W-1:0] address, input logic kind);
    in_t item;
    item.address = address;
    item.kind    = kind;
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) begin
      backpressure_cycles++;
      @(posedge clk);
    end
    ledger.note_address(item);
    @(negedge clk);
  endtask

  // Lower valid and wait on the falling edge until every predicted
  // transaction has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (ledger.outstanding() != 0) begin
      @(negedge clk);
    end
  endtask

  // Draw a random address: mostly spellable callsigns built digit by digit,
  // with the reserved classes, boundary neighbours and raw 48-bit noise mixed in.
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] a;
    int unsigned       roll;
    roll = $urandom_range(99);
    a = '0;
    if (roll < 60) begin
      for (int i = 0; i < CHARS_PER_ADDR; i++) begin
        a = a * 40 + ADDR_W'($urandom_range(39));
      end
    end else if (roll < 75) begin
      a = ADDR_W'({$urandom(), $urandom()});
    end else if (roll < 80) begin
      a = SPELL_CEILING - ADDR_W'($urandom_range(1, 64));
    end else if (roll < 85) begin
      a = SPELL_CEILING + ADDR_W'($urandom_range(64));
    end else if (roll < 88) begin
      a = ALL_ONES - ADDR_W'($urandom_range(1, 16));
    end else if (roll < 92) begin
      a = ADDR_W'($urandom_range(1, 1600));
    end else if (roll < 96) begin
      a = ALL_ONES;
    end else begin
      a = '0;
    end
    return a;
  endfunction

  // Receiver: drive stall on the falling edge. A hold-off request is counted
  // out here, in cycles, independently of the sender.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_OFF_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 13);
      end
    end
  end

  // Sample the output channel on the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      ledger.check_character(out_data);
    end
  end

  initial begin
    logic [ADDR_W-1:0] a;
    ledger = new();
    calm = 1'b0;
    hold_req = 1'b0;
    backpressure_cycles = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every special class with both kinds, the spelling boundary
    // on both sides, and addresses whose digits run through the whole alphabet.
    send_address(ALL_ONES, 1'b0);
    send_address(ALL_ONES, 1'b1);
    send_address('0, 1'b0);
    send_address('0, 1'b1);
    send_address(SPELL_CEILING, 1'b0);
    send_address(SPELL_CEILING - 1, 1'b1);
    send_address(SPELL_CEILING + 1, 1'b0);
    send_address(ALL_ONES - 1, 1'b1);
    send_address(48'd1, 1'b0);
    send_address(48'd39, 1'b1);
    send_address(48'd40, 1'b0);
    for (int first = 0; first < 40; first += CHARS_PER_ADDR) begin
      a = '0;
      for (int i = CHARS_PER_ADDR - 1; i >= 0; i--) begin
        a = a * 40 + ADDR_W'((first + i) % 40);
      end
      send_address(a, first[0]);
    end

    // Random, with idling on both sides.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 140) begin
        // sender pause: let the block empty completely
        drain_results();
        @(negedge clk);
      end
      if (n == 160) begin
        // receiver holds off while the sender keeps offering, so the
        // internal queue fills and the input backs up
        hold_req = 1'b1;
      end
      if (n == 220) begin
        calm = 1'b1;
      end
      if (n == 330) begin
        calm = 1'b0;
      end
      send_address(pick_address(), 1'($urandom_range(1)));
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d spelled callsigns and %0d special addresses, %0d output transactions.",
             ledger.spelled, ledger.flagged, ledger.results_seen);
    $display("Input held back for %0d cycles; %0d mismatches.",
             backpressure_cycles, ledger.errors);
    if (ledger.errors == 0 && ledger.outstanding() == 0) begin
      $display("base40_callsign_decoder_tb: clean");
    end else begin
      $display("base40_callsign_decoder_tb: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timed out with %0d transactions still awaited.", ledger.outstanding());
    $display("base40_callsign_decoder_tb: errors");
    $finish;
  end

endmodule
